// ===== hdl/omlf_pkg.sv =====
`timescale 1ns / 1ps

package omlf_pkg;

   // Table and port geometry.
   localparam int TABLE_ENTRIES = 256;
   localparam int PORT_COUNT    = 16;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);

   localparam logic [39:0] AGE_LIMIT_RESET = 40'd300000000000;
   localparam logic [47:0] BCAST_MAC       = 48'hFFFF_FFFF_FFFF;

   // Result actions.
   localparam logic [2:0] ACT_DROP     = 3'd0;
   localparam logic [2:0] ACT_PASS     = 3'd1;
   localparam logic [2:0] ACT_REDIRECT = 3'd2;
   localparam logic [2:0] ACT_ENCAP    = 3'd3;
   localparam logic [2:0] ACT_DECAP    = 3'd4;
   localparam logic [2:0] ACT_ABORT    = 3'd5;

   // Commands and descriptor codes.
   localparam logic       CMD_FRAME   = 1'b0;
   localparam logic       CMD_AGE     = 1'b1;
   localparam logic [1:0] TYPE_ARP    = 2'd0;
   localparam logic [1:0] TYPE_IPV4   = 2'd1;
   localparam logic [1:0] TYPE_OTHER  = 2'd2;
   localparam logic [1:0] ARP_REQUEST = 2'd0;
   localparam logic [1:0] ARP_REPLY   = 2'd1;
   localparam logic [1:0] ARP_OTHER   = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_INTERNAL_MASK = 2'd0;
   localparam logic [1:0] CSR_KNOWN_MASK    = 2'd1;
   localparam logic [1:0] CSR_AGE_LIMIT     = 2'd2;

   typedef struct packed {
      logic        command;
      logic [3:0]  ingress_port;
      logic [47:0] src_mac;
      logic [47:0] dst_mac;
      logic [31:0] border_src_ip;
      logic        headers_ok;
      logic [1:0]  inner_type;
      logic        inner_ok;
      logic [1:0]  arp_op;
      logic        arp_ips_equal;
      logic [63:0] now_ns;
      logic [7:0]  entry_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [3:0]  out_port;
      logic [31:0] tunnel_dst_ip;
      logic        learn_failed;
      logic        aged_out;
   } rsp_type;

   // Search token that walks down the row of cells.
   typedef struct packed {
      logic             active;
      logic             src_hit;
      logic             free_found;
      logic [IDX_W-1:0] free_idx;
      logic             dst_hit;
      logic [3:0]       dst_port;
      logic [31:0]      dst_ip;
      logic             age_valid;
      logic [63:0]      age_seen;
   } token_type;

   // Keys of the item in flight, broadcast to all cells.
   typedef struct packed {
      logic             learn_en;
      logic [47:0]      src_mac;
      logic [47:0]      dst_mac;
      logic [63:0]      now_ns;
      logic [IDX_W-1:0] age_sel;
   } job_type;

   // Entry write or removal, broadcast to all cells.
   typedef struct packed {
      logic             wr_en;
      logic             clr_en;
      logic [IDX_W-1:0] idx;
      logic [47:0]      mac;
      logic [3:0]       port;
      logic [31:0]      ip;
      logic [63:0]      seen;
   } wr_type;

   function automatic logic port_bit(logic [15:0] mask, logic [3:0] port);
      return (32'(port) < PORT_COUNT) && mask[port];
   endfunction

endpackage

// ===== hdl/omlf_cell.sv =====
`timescale 1ns / 1ps

module omlf_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [omlf_pkg::IDX_W-1:0]    cell_idx,
   input  omlf_pkg::job_type             job,
   input  omlf_pkg::wr_type              wr,
   input  omlf_pkg::token_type           tok_i,
   output omlf_pkg::token_type           tok_o
);
   import omlf_pkg::*;

   logic        valid_ff, valid_in;
   logic [47:0] mac_ff, mac_in;
   logic [3:0]  port_ff, port_in;
   logic [31:0] ip_ff, ip_in;
   logic [63:0] seen_ff, seen_in;
   token_type   tok_ff, tok_in;
   logic        src_m, dst_m, here;

   assign src_m = valid_ff && (mac_ff == job.src_mac);
   assign dst_m = valid_ff && (mac_ff == job.dst_mac);
   assign here  = (wr.idx == cell_idx);

   // Token update as it passes this entry.
   always_comb begin
      tok_in = tok_i;
      if (tok_i.active) begin
         tok_in.src_hit = tok_i.src_hit | src_m;
         if (!valid_ff && !tok_i.free_found) begin
            tok_in.free_found = 1'b1;
            tok_in.free_idx   = cell_idx;
         end
         if (dst_m && !tok_i.dst_hit) begin
            tok_in.dst_hit  = 1'b1;
            tok_in.dst_port = port_ff;
            tok_in.dst_ip   = ip_ff;
         end
         if (job.age_sel == cell_idx) begin
            tok_in.age_valid = valid_ff;
            tok_in.age_seen  = seen_ff;
         end
      end
   end

   // Entry update: new entry, removal, or time refresh of the first source hit.
   always_comb begin
      valid_in = valid_ff;
      mac_in   = mac_ff;
      port_in  = port_ff;
      ip_in    = ip_ff;
      seen_in  = seen_ff;
      if (wr.wr_en && here) begin
         valid_in = 1'b1;
         mac_in   = wr.mac;
         port_in  = wr.port;
         ip_in    = wr.ip;
         seen_in  = wr.seen;
      end else if (wr.clr_en && here) begin
         valid_in = 1'b0;
      end else if (tok_i.active && job.learn_en && src_m && !tok_i.src_hit) begin
         seen_in = job.now_ns;
      end
   end

   always_ff @(posedge clock) begin
      mac_ff  <= mac_in;
      port_ff <= port_in;
      ip_ff   <= ip_in;
      seen_ff <= seen_in;
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in;
      end
   end

   assign tok_o = tok_ff;

endmodule

// ===== hdl/overlay_mac_learning_forwarder.sv =====
`timescale 1ns / 1ps
// An item accepted while idle gets its result strobe once the search token has walked the
// registered row of table cells and then the result register.
// A new item is taken only once the last one is done; busy is low while the result shows.
// Reset: synchronous, clears all entry valid bits at once and loads the register defaults.
// Results cannot be stalled by the receiver.

module overlay_mac_learning_forwarder (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  omlf_pkg::req_type  req_item,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [39:0]        csr_wdata,
   output logic               rsp_valid,
   output omlf_pkg::rsp_type  rsp_item
);
   import omlf_pkg::*;

   logic        busy_ff, inj_ff, rsp_valid_ff;
   rsp_type     rsp_ff, rsp_in;
   req_type     req_ff;
   job_type     job_ff, job_in;
   logic [15:0] internal_ff, known_ff;
   logic [39:0] age_limit_ff;
   logic        age_range_ff;
   wr_type      wr;
   token_type   tok [0:TABLE_ENTRIES];
   token_type   t;
   logic        accept, done;
   logic [IDX_W+7:0] age_ext;

   assign accept  = start && !busy_ff;
   assign age_ext = {{IDX_W{1'b0}}, req_item.entry_index};

   // Keys of a new item.
   always_comb begin
      job_in.src_mac  = req_item.src_mac;
      job_in.dst_mac  = req_item.dst_mac;
      job_in.now_ns   = req_item.now_ns;
      job_in.age_sel  = age_ext[IDX_W-1:0];
      job_in.learn_en = (req_item.command == CMD_FRAME) && req_item.headers_ok
         && port_bit(known_ff, req_item.ingress_port)
         && (port_bit(internal_ff, req_item.ingress_port)
             || req_item.inner_type == TYPE_ARP || req_item.inner_type == TYPE_IPV4);
   end

   // Row of table cells.
   assign tok[0] = '{active: inj_ff, default: '0};

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      omlf_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (IDX_W'(i)),
         .job      (job_ff),
         .wr       (wr),
         .tok_i    (tok[i]),
         .tok_o    (tok[i+1])
      );
   end

   assign t    = tok[TABLE_ENTRIES];
   assign done = t.active;

   // Final decision once the token leaves the last cell.
   always_comb begin
      logic        new_entry, hit, lookup;
      logic [3:0]  hport;
      logic [31:0] hip, border;
      logic [63:0] idle;
      new_entry = job_ff.learn_en && !t.src_hit;
      border    = port_bit(internal_ff, req_ff.ingress_port) ? 32'd0 : req_ff.border_src_ip;
      if (new_entry && (req_ff.dst_mac == req_ff.src_mac)) begin
         hit   = t.free_found;
         hport = req_ff.ingress_port;
         hip   = border;
      end else begin
         hit   = t.dst_hit;
         hport = t.dst_port;
         hip   = t.dst_ip;
      end
      idle   = req_ff.now_ns - t.age_seen;
      lookup = 1'b0;

      rsp_in = '{action: ACT_DROP, default: '0};
      wr.wr_en  = done && new_entry && t.free_found;
      wr.clr_en = 1'b0;
      wr.idx    = t.free_idx;
      wr.mac    = req_ff.src_mac;
      wr.port   = req_ff.ingress_port;
      wr.ip     = border;
      wr.seen   = req_ff.now_ns;

      if (req_ff.command == CMD_AGE) begin
         wr.wr_en = 1'b0;
         wr.idx   = job_ff.age_sel;
         if (age_range_ff && t.age_valid && (idle > {24'd0, age_limit_ff})) begin
            rsp_in.aged_out = 1'b1;
            wr.clr_en       = done;
         end
      end else if (!req_ff.headers_ok) begin
         rsp_in.action = ACT_DROP;
      end else if (!port_bit(known_ff, req_ff.ingress_port)) begin
         rsp_in.action = ACT_ABORT;
      end else if (port_bit(internal_ff, req_ff.ingress_port)) begin
         rsp_in.learn_failed = new_entry && !t.free_found;
         if (!hit) begin
            rsp_in.action = ACT_PASS;
         end else if (!port_bit(known_ff, hport)) begin
            rsp_in.action = ACT_ABORT;
         end else if (port_bit(internal_ff, hport)) begin
            rsp_in.action   = ACT_REDIRECT;
            rsp_in.out_port = hport;
         end else begin
            rsp_in.action        = ACT_ENCAP;
            rsp_in.out_port      = hport;
            rsp_in.tunnel_dst_ip = hip;
         end
      end else if (job_ff.learn_en) begin
         rsp_in.learn_failed = new_entry && !t.free_found;
         if (!req_ff.inner_ok) begin
            rsp_in.action = ACT_DROP;
         end else if (req_ff.inner_type == TYPE_ARP) begin
            if (req_ff.arp_op == ARP_REQUEST) begin
               rsp_in.action = ACT_PASS;
            end else if (req_ff.arp_op == ARP_REPLY) begin
               if (req_ff.arp_ips_equal && req_ff.dst_mac == BCAST_MAC) begin
                  rsp_in.action = ACT_PASS;
               end else begin
                  lookup = 1'b1;
               end
            end
         end else begin
            lookup = 1'b1;
         end
         if (lookup && hit) begin
            if (!port_bit(known_ff, hport)) begin
               rsp_in.action = ACT_ABORT;
            end else if (port_bit(internal_ff, hport)) begin
               rsp_in.action   = ACT_DECAP;
               rsp_in.out_port = hport;
            end
         end
      end
   end

   // Control, item registers and configuration.
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff       <= req_item;
         job_ff       <= job_in;
         age_range_ff <= age_ext < (IDX_W+8)'(TABLE_ENTRIES);
      end
      rsp_ff <= rsp_in;
      if (reset) begin
         busy_ff      <= 1'b0;
         inj_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         internal_ff  <= 16'd0;
         known_ff     <= 16'd0;
         age_limit_ff <= AGE_LIMIT_RESET;
      end else begin
         inj_ff       <= accept;
         rsp_valid_ff <= done;
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (done) begin
            busy_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_INTERNAL_MASK: internal_ff  <= csr_wdata[15:0];
               CSR_KNOWN_MASK:    known_ff     <= csr_wdata[15:0];
               CSR_AGE_LIMIT:     age_limit_ff <= csr_wdata;
               default:           ;
            endcase
         end
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // The token only travels while an item is in flight.
   assert property (@(posedge clock) disable iff (reset) done |-> busy_ff)
      else $error("search token outside a busy period");
   // A result follows in the cycle after the token leaves the row, with busy low.
   assert property (@(posedge clock) disable iff (reset) done |=> rsp_valid_ff && !busy_ff)
      else $error("result strobe missing after search");
   // Injection happens only right after an accept.
   assert property (@(posedge clock) disable iff (reset) inj_ff |-> $past(accept))
      else $error("token injected without an accepted item");
   // Age results never report a learn failure.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.aged_out |-> !rsp_ff.learn_failed && rsp_ff.action == ACT_DROP)
      else $error("age result carries frame fields");

endmodule
